FILE: src/ring_buffer_linear_resampler_unit_macros.svh
// Assertion macros for the resampler RTL.
`ifndef RING_BUFFER_LINEAR_RESAMPLER_UNIT_MACROS_SVH
`define RING_BUFFER_LINEAR_RESAMPLER_UNIT_MACROS_SVH

`ifndef SYNTH
`define RBR_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define RBR_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define RBR_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define RBR_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

FILE: src/rbr_pkg.sv
`timescale 1ns / 1ps
package rbr_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int STEP_W    = 20;
  localparam int PERIOD_W  = 13;
  localparam int POS_W     = 12;
  localparam int PHASE_W   = 32;
  localparam int IDX_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int CMP_W     = 17;
  localparam int SUM_W     = 18;
  localparam int PROD_W    = 42;
  localparam int CFG_IDX_W = 2;

  localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd65536;
  localparam logic [STEP_W-1:0]   STEP_MAX     = 20'd524288;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 13'd256;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_SOURCE = 2'd2;

  typedef enum logic {
    OP_WRITE,
    OP_PULL
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic [PERIOD_W-1:0] period;
    logic                mono;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ_N,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage

FILE: src/rbr_ram.sv
`timescale 1ns / 1ps
module rbr_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: src/rbr_front.sv
`timescale 1ns / 1ps
module rbr_front
  import rbr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic signed [SAMPLE_W-1:0] in_left,
  input  logic signed [SAMPLE_W-1:0] in_right,
  output queue_head_t                head,
  input  logic                       pop
);

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      new_item;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    new_item.op    = in_action ? OP_PULL : OP_WRITE;
    new_item.left  = in_left;
    new_item.right = in_right;
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

FILE: src/rbr_back.sv
`timescale 1ns / 1ps
`include "ring_buffer_linear_resampler_unit_macros.svh"
module rbr_back
  import rbr_pkg::*;
#(
  parameter int RING_FRAMES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  queue_head_t                head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left,
  output logic signed [SAMPLE_W-1:0] out_right,
  output logic                       out_last_of_period,
  output logic                       out_starved
);

  localparam int PTR_W = $clog2(RING_FRAMES);
  localparam int CNT_W = $clog2(RING_FRAMES + 1);
  localparam logic [SUM_W-1:0] RING_S = SUM_W'(RING_FRAMES);
  localparam int FRAME_W = 2 * SAMPLE_W;
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int BL_W = SAMPLE_W + 2;

  state_t state_r, state_nxt;

  logic [PTR_W-1:0]   write_pos_r, read_pos_r;
  logic [CNT_W-1:0]   fill_r, psc_r;
  logic [POS_W-1:0]   out_pos_r;
  logic [PHASE_W-1:0] phase_r;
  logic [CMP_W-1:0]   need_r;

  logic [PTR_W-1:0] p_r;
  logic             use_next_r, inrange_r, starved_r;
  logic signed [SAMPLE_W-1:0] a_l_r, a_r_r;
  logic signed [PROD_W-1:0]   prod_l_r, prod_r_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_left_r, out_right_r;
  logic                       out_last_r, out_starved_r;

  // period start planning
  logic                  period_start;
  logic [CNT_W-1:0]      psc_eff;
  logic [PHASE_W-1:0]    phase_eff;
  logic [IDX_W-1:0]      idx;
  logic [SUM_W-1:0]      p_sum, n_sum, rp_sum, wp_sum;
  logic [PTR_W-1:0]      p_calc, n_calc, rp_calc, wp_calc;
  logic [2*STEP_W:0]     need_prod;
  logic [2*STEP_W+1:0]   need_ceil;

  logic                  ring_full;
  logic                  ram_we;
  logic [PTR_W-1:0]      ram_raddr;
  logic [FRAME_W-1:0]    ram_rdata;
  logic                  out_load;
  logic                  last;

  logic signed [DIFF_W-1:0] diff_l, diff_r;
  logic signed [PROD_W-1:0] rnd_l, rnd_r;
  logic [BL_W-1:0]          bl_l, bl_r;
  logic                     emit;

  assign need_prod = (2*STEP_W+1)'(cfg.period) * (2*STEP_W+1)'(cfg.step);
  assign need_ceil = (2*STEP_W+2)'(need_prod) + (2*STEP_W+2)'(16'hFFFF);

  assign period_start = (out_pos_r == '0);
  assign psc_eff   = period_start
                   ? ((need_r < CMP_W'(fill_r)) ? need_r[CNT_W-1:0] : fill_r)
                   : psc_r;
  assign phase_eff = period_start ? '0 : phase_r;
  assign idx       = phase_eff[PHASE_W-1:PHASE_W-IDX_W];

  assign p_sum  = SUM_W'(read_pos_r) + SUM_W'(idx);
  assign p_calc = (p_sum >= RING_S) ? PTR_W'(p_sum - RING_S) : PTR_W'(p_sum);
  assign n_sum  = SUM_W'(p_r) + SUM_W'(1);
  assign n_calc = !use_next_r ? p_r : ((n_sum == RING_S) ? '0 : PTR_W'(n_sum));
  assign rp_sum = SUM_W'(read_pos_r) + SUM_W'(psc_r);
  assign rp_calc = (rp_sum >= RING_S) ? PTR_W'(rp_sum - RING_S) : PTR_W'(rp_sum);
  assign wp_sum = SUM_W'(write_pos_r) + SUM_W'(1);
  assign wp_calc = (wp_sum == RING_S) ? '0 : PTR_W'(wp_sum);

  assign ring_full = (SUM_W'(fill_r) == RING_S);
  assign last = ((PERIOD_W'(out_pos_r) + PERIOD_W'(1)) >= cfg.period);

  rbr_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (RING_FRAMES)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pos_r),
    .wdata ({head.item.left, head.item.right}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid && head.item.op == OP_PULL) begin
          state_nxt = ST_READ_N;
        end
      end
      ST_READ_N: state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = n_calc;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        pop       = head.valid;
        ram_we    = head.valid && head.item.op == OP_WRITE && !ring_full;
        ram_raddr = p_calc;
      end
      ST_OUT:    out_load = !out_valid_r || !out_stall;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  assign diff_l = DIFF_W'(signed'(ram_rdata[FRAME_W-1:SAMPLE_W])) - DIFF_W'(a_l_r);
  assign diff_r = DIFF_W'(signed'(ram_rdata[SAMPLE_W-1:0])) - DIFF_W'(a_r_r);
  assign rnd_l  = prod_l_r + PROD_W'(32768);
  assign rnd_r  = prod_r_r + PROD_W'(32768);
  assign bl_l   = BL_W'(a_l_r) + rnd_l[PROD_W-1:FRAC_W];
  assign bl_r   = BL_W'(a_r_r) + rnd_r[PROD_W-1:FRAC_W];
  assign emit   = inrange_r && !starved_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      write_pos_r <= '0;
      read_pos_r  <= '0;
      fill_r      <= '0;
      out_pos_r   <= '0;
      psc_r       <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        write_pos_r <= wp_calc;
        fill_r      <= fill_r + CNT_W'(1);
      end
      if (pop && head.item.op == OP_PULL) begin
        psc_r   <= psc_eff;
        phase_r <= phase_eff;
      end
      if (out_load) begin
        if (last) begin
          read_pos_r <= rp_calc;
          fill_r     <= fill_r - psc_r;
          psc_r      <= '0;
          out_pos_r  <= '0;
          phase_r    <= '0;
        end else begin
          out_pos_r <= out_pos_r + POS_W'(1);
          phase_r   <= phase_r + PHASE_W'(cfg.step);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    need_r <= need_ceil[FRAC_W+CMP_W-1:FRAC_W];
    if (state_r == ST_IDLE) begin
      p_r        <= p_calc;
      use_next_r <= (CMP_W'(idx) + CMP_W'(1)) < CMP_W'(fill_r);
      inrange_r  <= CMP_W'(idx) < CMP_W'(psc_eff);
      starved_r  <= (psc_eff == '0);
    end
    if (state_r == ST_READ_N) begin
      a_l_r <= ram_rdata[FRAME_W-1:SAMPLE_W];
      a_r_r <= ram_rdata[SAMPLE_W-1:0];
    end
    if (state_r == ST_MUL) begin
      prod_l_r <= PROD_W'(diff_l * signed'({1'b0, phase_r[FRAC_W-1:0]}));
      prod_r_r <= PROD_W'(diff_r * signed'({1'b0, phase_r[FRAC_W-1:0]}));
    end
    if (out_load) begin
      out_left_r    <= emit ? bl_l[SAMPLE_W-1:0] : '0;
      out_right_r   <= emit ? (cfg.mono ? bl_l[SAMPLE_W-1:0] : bl_r[SAMPLE_W-1:0]) : '0;
      out_last_r    <= last;
      out_starved_r <= starved_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left           = out_left_r;
  assign out_right          = out_right_r;
  assign out_last_of_period = out_last_r;
  assign out_starved        = out_starved_r;

  `RBR_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, SUM_W'(fill_r) <= RING_S)
  `RBR_ASSERT_IMP(a_reserve_bound, clk, rst_n, 1'b1, psc_r <= fill_r)
  `RBR_ASSERT_IMP(a_pop_idle, clk, rst_n, pop, state_r == ST_IDLE)
  `RBR_ASSERT_NXT(a_period_end, clk, rst_n, out_load && last, out_pos_r == '0 && phase_r == '0 && out_valid_r)

endmodule

FILE: src/ring_buffer_linear_resampler_unit.sv
`timescale 1ns / 1ps
// Linear-interpolating resampler over a ring of RING_FRAMES stereo frames.
// Transactions with in_action low write a frame (dropped when the ring is
// full); with in_action high they pull one interpolated output frame, with
// out_last_of_period on the last frame of each period and out_starved when
// the period found no buffered source. Step and period registers are clamped
// when written (step to 1..524288, period to 1..4096); cfg_index 3 is ignored.
// A two-entry input queue decouples acceptance from execution, and an output
// register holds a finished frame while the next transactions are taken in.
// A write executes in ST_IDLE; a pull steps through ST_READ_N, ST_MUL and
// ST_OUT: the single read port of the ring fetches the two neighboring frames
// one after the other, followed by a multiply stage and a rounding stage that
// waits while the output is stalled. Ring contents are not cleared by reset.
module ring_buffer_linear_resampler_unit
  import rbr_pkg::*;
#(
  parameter int RING_FRAMES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [STEP_W-1:0]           cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic signed [SAMPLE_W-1:0]  in_left,
  input  logic signed [SAMPLE_W-1:0]  in_right,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  out_left,
  output logic signed [SAMPLE_W-1:0]  out_right,
  output logic                        out_last_of_period,
  output logic                        out_starved
);

  cfg_t                cfg_r;
  logic [STEP_W-1:0]   step_clamped;
  logic [PERIOD_W-1:0] period_clamped;
  queue_head_t         head;
  logic                pop;

  always_comb begin
    if (cfg_wdata == '0) begin
      step_clamped = STEP_W'(1);
    end else if (cfg_wdata > STEP_MAX) begin
      step_clamped = STEP_MAX;
    end else begin
      step_clamped = cfg_wdata;
    end
    if (cfg_wdata[PERIOD_W-1:0] == '0) begin
      period_clamped = PERIOD_W'(1);
    end else if (cfg_wdata[PERIOD_W-1:0] > PERIOD_MAX) begin
      period_clamped = PERIOD_MAX;
    end else begin
      period_clamped = cfg_wdata[PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step   <= STEP_RESET;
      cfg_r.period <= PERIOD_RESET;
      cfg_r.mono   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_STEP:    cfg_r.step   <= step_clamped;
        CFG_PERIOD:      cfg_r.period <= period_clamped;
        CFG_MONO_SOURCE: cfg_r.mono   <= cfg_wdata[0];
        default:         cfg_r        <= cfg_r;
      endcase
    end
  end

  rbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_left   (in_left),
    .in_right  (in_right),
    .head      (head),
    .pop       (pop)
  );

  rbr_back #(
    .RING_FRAMES (RING_FRAMES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left           (out_left),
    .out_right          (out_right),
    .out_last_of_period (out_last_of_period),
    .out_starved        (out_starved)
  );

endmodule
